// ----- rtl/core/glp_pkg.sv -----
package glp_pkg;

    localparam int NODES_MAX     = 1024;
    localparam int NEIGHBORS_MAX = 8192;
    localparam int NODE_W        = 10;
    localparam int SLOT_W        = 13;
    localparam int VALUE_W       = 14;
    localparam int COUNT_W       = 14;
    localparam int NCNT_W        = 11;
    localparam int ROUND_W       = 16;
    localparam int LFSR_W        = 32;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

    localparam logic [1:0] OP_OFFSET   = 2'd0;
    localparam logic [1:0] OP_NEIGHBOR = 2'd1;
    localparam logic [1:0] OP_RUN      = 2'd2;
    localparam logic [1:0] OP_READ     = 2'd3;

    localparam logic [1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [1:0] ST_CONVERGED = 2'd1;
    localparam logic [1:0] ST_LIMIT     = 2'd2;

    localparam logic [1:0] REG_NODE_COUNT   = 2'd0;
    localparam logic [1:0] REG_SHUFFLE_SEED = 2'd1;
    localparam logic [1:0] REG_ROUND_LIMIT  = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [SLOT_W-1:0]  index;
        logic [VALUE_W-1:0] value;
    } glp_req_t;

    typedef struct packed {
        logic [NODE_W-1:0]  label;
        logic [1:0]         status;
        logic [ROUND_W-1:0] rounds_taken;
    } glp_rsp_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_RD_OUT,
        CMD_RUN_START,
        CMD_INIT_WR,
        CMD_CHK_START,
        CMD_DONE_CONV,
        CMD_DONE_LIM,
        CMD_ORD_RD,
        CMD_ND_LOAD,
        CMD_M_ES0,
        CMD_M_ES1,
        CMD_M_HI,
        CMD_NB_RD,
        CMD_LAB_RD,
        CMD_C_CLR,
        CMD_CNT_START,
        CMD_P_CNT,
        CMD_P_INC,
        CMD_CK_LAB,
        CMD_I_INC,
        CMD_SH_START,
        CMD_SH_STEP,
        CMD_DIV_GO,
        CMD_DIV_TAKE,
        CMD_SW_RA,
        CMD_SW_RB,
        CMD_SW_W1,
        CMD_SW_W2,
        CMD_UPD_START,
        CMD_UPD_WR,
        CMD_ROUND_END
    } glp_cmd_t;

    typedef struct packed {
        logic i_at_n;
        logic i_zero;
        logic k_done;
        logic mismatch;
        logic limit_hit;
        logic div_done;
    } glp_stat_t;

endpackage

// ----- rtl/core/graph_label_propagation_core.sv -----
// Label propagation engine for graphs of up to 1024 nodes and 8192 adjacency slots. Offset
// and neighbor load requests and label reads are taken one at a time: a load is answered in
// the cycle after it is accepted, and a read after passing through the S_RD state. A run
// request occupies the block until it converges or hits the round limit. Each evaluation of
// a node's neighbor mode walks the single-port neighbor, label and count memories in two
// passes; a round costs one such evaluation per node for the convergence check, stopping at
// the first mismatch, a shuffle step per node dominated by the bit-serial remainder unit,
// and one more evaluation per node for the update. Configuration writes are always accepted,
// but the user must write them only while the block is idle; the block does not enforce it.
module graph_label_propagation_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  glp_pkg::glp_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output glp_pkg::glp_rsp_t rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import glp_pkg::*;

    glp_cmd_t  cmd;
    glp_stat_t stat;

    assign cfg_ready = 1'b1;

    glp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req.op),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    glp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .rsp       (rsp)
    );

endmodule

// ----- rtl/core/glp_rem.sv -----
module glp_rem (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [glp_pkg::LFSR_W-1:0] dividend,
    input  logic [glp_pkg::NCNT_W-1:0] divisor,
    output logic                      done,
    output logic [glp_pkg::NCNT_W-1:0] remainder
);
    import glp_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [LFSR_W-1:0] quo_reg;
    logic [NCNT_W-1:0] div_reg;
    logic [NCNT_W-1:0] rem_reg;
    logic [NCNT_W:0]   trial;
    logic [NCNT_W:0]   trial_sub;

    assign trial     = {rem_reg, quo_reg[LFSR_W-1]};
    assign trial_sub = (trial >= {1'b0, div_reg}) ? (trial - {1'b0, div_reg}) : trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[LFSR_W-2:0], 1'b0};
            rem_reg <= trial_sub[NCNT_W-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/core/glp_dp.sv -----
module glp_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  glp_pkg::glp_cmd_t cmd,
    input  glp_pkg::glp_req_t req,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output glp_pkg::glp_stat_t stat,
    output glp_pkg::glp_rsp_t rsp
);
    import glp_pkg::*;

    logic [VALUE_W-1:0] es_mem [0:NODES_MAX];
    logic [VALUE_W-1:0] nb_mem [0:NEIGHBORS_MAX-1];
    logic [NODE_W-1:0]  lab_mem [0:NODES_MAX-1];
    logic [NODE_W-1:0]  ord_mem [0:NODES_MAX-1];
    logic [COUNT_W-1:0] cnt_mem [0:NODES_MAX-1];

    logic [NCNT_W-1:0]  es_addr;
    logic               es_we;
    logic [VALUE_W-1:0] es_rd_reg;
    logic [SLOT_W-1:0]  nb_addr;
    logic               nb_we;
    logic [VALUE_W-1:0] nb_rd_reg;
    logic [NODE_W-1:0]  lab_addr;
    logic               lab_we;
    logic [NODE_W-1:0]  lab_wdata;
    logic [NODE_W-1:0]  lab_rd_reg;
    logic [NODE_W-1:0]  ord_addr;
    logic               ord_we;
    logic [NODE_W-1:0]  ord_wdata;
    logic [NODE_W-1:0]  ord_rd_reg;
    logic [NODE_W-1:0]  cnt_addr;
    logic               cnt_we;
    logic [COUNT_W-1:0] cnt_wdata;
    logic [COUNT_W-1:0] cnt_rd_reg;

    logic [NCNT_W-1:0]  n_cfg_reg;
    logic [LFSR_W-1:0]  seed_reg;
    logic [ROUND_W-1:0] limit_reg;
    logic [LFSR_W-1:0]  lfsr_reg;
    logic [ROUND_W-1:0] last_rounds_reg;

    logic [NCNT_W-1:0]  n_reg;
    logic [NCNT_W-1:0]  i_reg;
    logic [NODE_W-1:0]  nd_reg;
    logic [VALUE_W-1:0] k_reg;
    logic [VALUE_W-1:0] lo_reg;
    logic [VALUE_W-1:0] hi_reg;
    logic [COUNT_W-1:0] best_reg;
    logic [NODE_W-1:0]  best_lab_reg;
    logic [NODE_W-1:0]  lab_reg;
    logic               vok_reg;
    logic               rd_ok_reg;
    logic [NODE_W-1:0]  j_reg;
    logic [NODE_W-1:0]  tmp_reg;
    logic [ROUND_W-1:0] rounds_reg;
    glp_rsp_t           rsp_reg;

    logic [LFSR_W-1:0]  lfsr_step;
    logic [COUNT_W-1:0] cnt_inc;
    logic               div_start;
    logic               div_done;
    logic [NCNT_W-1:0]  div_rem;

    assign lfsr_step = lfsr_reg[0] ? ({1'b0, lfsr_reg[LFSR_W-1:1]} ^ LFSR_TAPS)
                                   : {1'b0, lfsr_reg[LFSR_W-1:1]};
    assign cnt_inc   = cnt_rd_reg + COUNT_W'(1);
    assign div_start = (cmd == CMD_DIV_GO);

    glp_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (lfsr_reg),
        .divisor   (i_reg + NCNT_W'(1)),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        es_addr   = req.index[NCNT_W-1:0];
        es_we     = 1'b0;
        nb_addr   = k_reg[SLOT_W-1:0];
        nb_we     = 1'b0;
        lab_addr  = i_reg[NODE_W-1:0];
        lab_we    = 1'b0;
        lab_wdata = i_reg[NODE_W-1:0];
        ord_addr  = i_reg[NODE_W-1:0];
        ord_we    = 1'b0;
        ord_wdata = i_reg[NODE_W-1:0];
        cnt_addr  = lab_rd_reg;
        cnt_we    = 1'b0;
        cnt_wdata = '0;
        case (cmd)
            CMD_ACCEPT:
            begin
                es_we    = (req.op == OP_OFFSET) &&
                           ({1'b0, req.index} <= (SLOT_W+1)'(NODES_MAX));
                nb_addr  = req.index;
                nb_we    = (req.op == OP_NEIGHBOR);
                lab_addr = req.index[NODE_W-1:0];
            end
            CMD_INIT_WR:
            begin
                lab_we = 1'b1;
                ord_we = 1'b1;
            end
            CMD_M_ES0: es_addr = {1'b0, nd_reg};
            CMD_M_ES1: es_addr = {1'b0, nd_reg} + NCNT_W'(1);
            CMD_LAB_RD: lab_addr = nb_rd_reg[NODE_W-1:0];
            CMD_C_CLR: cnt_we = vok_reg;
            CMD_P_INC:
            begin
                cnt_addr  = lab_reg;
                cnt_we    = vok_reg;
                cnt_wdata = cnt_inc;
            end
            CMD_CK_LAB: lab_addr = nd_reg;
            CMD_SW_RB: ord_addr = j_reg;
            CMD_SW_W1:
            begin
                ord_we    = 1'b1;
                ord_wdata = ord_rd_reg;
            end
            CMD_SW_W2:
            begin
                ord_addr  = j_reg;
                ord_we    = 1'b1;
                ord_wdata = tmp_reg;
            end
            CMD_UPD_WR:
            begin
                lab_addr  = nd_reg;
                lab_we    = 1'b1;
                lab_wdata = best_lab_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (es_we)
        begin
            es_mem[es_addr] <= req.value;
        end
        es_rd_reg <= es_mem[es_addr];
    end

    always_ff @(posedge clk)
    begin
        if (nb_we)
        begin
            nb_mem[nb_addr] <= req.value;
        end
        nb_rd_reg <= nb_mem[nb_addr];
    end

    always_ff @(posedge clk)
    begin
        if (lab_we)
        begin
            lab_mem[lab_addr] <= lab_wdata;
        end
        lab_rd_reg <= lab_mem[lab_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_addr] <= ord_wdata;
        end
        ord_rd_reg <= ord_mem[ord_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_addr] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[cnt_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_cfg_reg       <= NCNT_W'(1);
            seed_reg        <= LFSR_W'(1);
            limit_reg       <= ROUND_W'(1000);
            lfsr_reg        <= LFSR_W'(1);
            last_rounds_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NODE_COUNT:   n_cfg_reg <= cfg_data[NCNT_W-1:0];
                    REG_SHUFFLE_SEED: seed_reg  <= cfg_data;
                    REG_ROUND_LIMIT:  limit_reg <= cfg_data[ROUND_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            case (cmd)
                CMD_RUN_START: lfsr_reg <= (seed_reg == '0) ? LFSR_W'(1) : seed_reg;
                CMD_SH_STEP:   lfsr_reg <= lfsr_step;
                CMD_DONE_CONV,
                CMD_DONE_LIM:  last_rounds_reg <= rounds_reg;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_ACCEPT:
            begin
                rd_ok_reg <= ({1'b0, req.index} < (SLOT_W+1)'(NODES_MAX));
                rsp_reg   <= '{label: '0, status: ST_ACCEPTED, rounds_taken: last_rounds_reg};
            end
            CMD_RD_OUT:
            begin
                rsp_reg <= '{label: rd_ok_reg ? lab_rd_reg : '0, status: ST_ACCEPTED,
                             rounds_taken: last_rounds_reg};
            end
            CMD_RUN_START:
            begin
                n_reg      <= (n_cfg_reg > NCNT_W'(NODES_MAX)) ? NCNT_W'(NODES_MAX)
                                                               : n_cfg_reg;
                i_reg      <= '0;
                rounds_reg <= '0;
            end
            CMD_INIT_WR: i_reg <= i_reg + NCNT_W'(1);
            CMD_CHK_START: i_reg <= '0;
            CMD_DONE_CONV:
            begin
                rsp_reg <= '{label: '0, status: ST_CONVERGED, rounds_taken: rounds_reg};
            end
            CMD_DONE_LIM:
            begin
                rsp_reg <= '{label: '0, status: ST_LIMIT, rounds_taken: rounds_reg};
            end
            CMD_ND_LOAD: nd_reg <= ord_rd_reg;
            CMD_M_ES1:
            begin
                k_reg  <= es_rd_reg;
                lo_reg <= es_rd_reg;
            end
            CMD_M_HI:
            begin
                hi_reg       <= (es_rd_reg > VALUE_W'(NEIGHBORS_MAX)) ?
                                VALUE_W'(NEIGHBORS_MAX) : es_rd_reg;
                best_reg     <= '0;
                best_lab_reg <= '0;
            end
            CMD_LAB_RD: vok_reg <= (nb_rd_reg < {3'b0, n_reg});
            CMD_C_CLR: k_reg <= k_reg + VALUE_W'(1);
            CMD_CNT_START: k_reg <= lo_reg;
            CMD_P_CNT: lab_reg <= lab_rd_reg;
            CMD_P_INC:
            begin
                k_reg <= k_reg + VALUE_W'(1);
                if (vok_reg && (cnt_inc > best_reg))
                begin
                    best_reg     <= cnt_inc;
                    best_lab_reg <= lab_reg;
                end
            end
            CMD_I_INC: i_reg <= i_reg + NCNT_W'(1);
            CMD_SH_START: i_reg <= n_reg - NCNT_W'(1);
            CMD_DIV_TAKE: j_reg <= div_rem[NODE_W-1:0];
            CMD_SW_RB: tmp_reg <= ord_rd_reg;
            CMD_SW_W2: i_reg <= i_reg - NCNT_W'(1);
            CMD_UPD_START: i_reg <= '0;
            CMD_UPD_WR: i_reg <= i_reg + NCNT_W'(1);
            CMD_ROUND_END:
            begin
                rounds_reg <= rounds_reg + ROUND_W'(1);
                i_reg      <= '0;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.i_at_n    = (i_reg == n_reg);
    assign stat.i_zero    = (i_reg == '0);
    assign stat.k_done    = (k_reg >= hi_reg);
    assign stat.mismatch  = (lab_rd_reg != best_lab_reg);
    assign stat.limit_hit = (rounds_reg >= limit_reg);
    assign stat.div_done  = div_done;
    assign rsp            = rsp_reg;

endmodule

// ----- rtl/core/glp_ctrl.sv -----
module glp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [1:0]         req_op,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  glp_pkg::glp_stat_t stat,
    output glp_pkg::glp_cmd_t  cmd
);
    import glp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_INIT, S_CHK, S_ND, S_M0, S_M1, S_M2,
        S_C0, S_C1, S_C2, S_P0, S_P1, S_P2, S_P3, S_CL, S_CC,
        S_LIM, S_SH, S_SD0, S_SDW, S_SA, S_SB, S_SW1, S_SW2, S_UO, S_UW
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ret_chk_reg;
    logic   ret_chk_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   accept;

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        ret_chk_next   = ret_chk_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd = CMD_ACCEPT;
                    case (req_op)
                        OP_RUN:
                        begin
                            cmd        = CMD_RUN_START;
                            state_next = S_INIT;
                        end
                        OP_READ: state_next = S_RD;
                        default: rsp_valid_next = 1'b1;
                    endcase
                end
            end
            S_RD:
            begin
                cmd            = CMD_RD_OUT;
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_INIT:
            begin
                if (stat.i_at_n)
                begin
                    cmd        = CMD_CHK_START;
                    state_next = S_CHK;
                end
                else
                begin
                    cmd = CMD_INIT_WR;
                end
            end
            S_CHK:
            begin
                if (stat.i_at_n)
                begin
                    cmd            = CMD_DONE_CONV;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd          = CMD_ORD_RD;
                    ret_chk_next = 1'b1;
                    state_next   = S_ND;
                end
            end
            S_ND:
            begin
                cmd        = CMD_ND_LOAD;
                state_next = S_M0;
            end
            S_M0:
            begin
                cmd        = CMD_M_ES0;
                state_next = S_M1;
            end
            S_M1:
            begin
                cmd        = CMD_M_ES1;
                state_next = S_M2;
            end
            S_M2:
            begin
                cmd        = CMD_M_HI;
                state_next = S_C0;
            end
            S_C0:
            begin
                if (stat.k_done)
                begin
                    cmd        = CMD_CNT_START;
                    state_next = S_P0;
                end
                else
                begin
                    cmd        = CMD_NB_RD;
                    state_next = S_C1;
                end
            end
            S_C1:
            begin
                cmd        = CMD_LAB_RD;
                state_next = S_C2;
            end
            S_C2:
            begin
                cmd        = CMD_C_CLR;
                state_next = S_C0;
            end
            S_P0:
            begin
                if (stat.k_done)
                begin
                    state_next = ret_chk_reg ? S_CL : S_UW;
                end
                else
                begin
                    cmd        = CMD_NB_RD;
                    state_next = S_P1;
                end
            end
            S_P1:
            begin
                cmd        = CMD_LAB_RD;
                state_next = S_P2;
            end
            S_P2:
            begin
                cmd        = CMD_P_CNT;
                state_next = S_P3;
            end
            S_P3:
            begin
                cmd        = CMD_P_INC;
                state_next = S_P0;
            end
            S_CL:
            begin
                cmd        = CMD_CK_LAB;
                state_next = S_CC;
            end
            S_CC:
            begin
                if (stat.mismatch)
                begin
                    state_next = S_LIM;
                end
                else
                begin
                    cmd        = CMD_I_INC;
                    state_next = S_CHK;
                end
            end
            S_LIM:
            begin
                if (stat.limit_hit)
                begin
                    cmd            = CMD_DONE_LIM;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd        = CMD_SH_START;
                    state_next = S_SH;
                end
            end
            S_SH:
            begin
                if (stat.i_zero)
                begin
                    cmd        = CMD_UPD_START;
                    state_next = S_UO;
                end
                else
                begin
                    cmd        = CMD_SH_STEP;
                    state_next = S_SD0;
                end
            end
            S_SD0:
            begin
                cmd        = CMD_DIV_GO;
                state_next = S_SDW;
            end
            S_SDW:
            begin
                if (stat.div_done)
                begin
                    cmd        = CMD_DIV_TAKE;
                    state_next = S_SA;
                end
            end
            S_SA:
            begin
                cmd        = CMD_SW_RA;
                state_next = S_SB;
            end
            S_SB:
            begin
                cmd        = CMD_SW_RB;
                state_next = S_SW1;
            end
            S_SW1:
            begin
                cmd        = CMD_SW_W1;
                state_next = S_SW2;
            end
            S_SW2:
            begin
                cmd        = CMD_SW_W2;
                state_next = S_SH;
            end
            S_UO:
            begin
                if (stat.i_at_n)
                begin
                    cmd        = CMD_ROUND_END;
                    state_next = S_CHK;
                end
                else
                begin
                    cmd          = CMD_ORD_RD;
                    ret_chk_next = 1'b0;
                    state_next   = S_ND;
                end
            end
            S_UW:
            begin
                cmd        = CMD_UPD_WR;
                state_next = S_UO;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_chk_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_chk_reg   <= ret_chk_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule
